// ===== rtl/core/particle_update_step_macros.svh =====
// Assertion shorthands for the particle update core.
// Both forms sample on the rising edge of clock and are off during reset.
`ifndef PARTICLE_UPDATE_STEP_MACROS_SVH
`define PARTICLE_UPDATE_STEP_MACROS_SVH

// Same-cycle implication.
`define PUP_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PUP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/pup_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pup_pkg
// Shared constants and types of the particle update pipeline.
// ----------------------------------------------------------------------------
package pup_pkg;

   // Default lane width of position and velocity.
   localparam int COORD_BITS_DEF = 20;

   // Fixed field widths.
   localparam int T_W      = 16;
   localparam int AGE_W    = 24;
   localparam int PACK_W   = 60;
   localparam int COL_W    = 48;
   localparam int CH_W     = 16;
   localparam int STR_W    = 20;
   // Quotient bits of the attraction divide; the quotient never exceeds 2^19.
   localparam int QUO_W    = 21;
   localparam int CSR_IDX_W = 1;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_ATTRACT_ENABLE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ATTRACT_STRENGTH = 1'd1;

   // Control bits that travel with every item.
   typedef struct packed {
      logic valid;
      logic alive;
      logic add_en;
   } pup_ctrl_type;

endpackage

// ===== rtl/core/pup_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pup_front
// Five pipeline stages: time-step products, position and damping update,
// direction to the parent, squared length and attraction numerators.
// ----------------------------------------------------------------------------
module pup_front #(
   parameter int COORD_BITS = pup_pkg::COORD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic [15:0]                       t_data,
   input  logic [23:0]                       age_data,
   input  logic [23:0]                       life_data,
   input  logic [59:0]                       pos_data,
   input  logic [59:0]                       vel_data,
   input  logic [59:0]                       par_data,
   input  logic                              stop_data,
   input  logic [47:0]                       col_data,
   input  logic [47:0]                       crate_data,
   input  logic signed [15:0]                size_data,
   input  logic signed [15:0]                srate_data,
   input  logic                              attract_en,
   input  logic signed [19:0]                attract_str,
   output pup_pkg::pup_ctrl_type             ctrl,
   output logic [2*COORD_BITS+2:0]           sq_sum,
   output logic [3*(COORD_BITS+22)-1:0]      numer,
   output logic [23:0]                       age_res,
   output logic [59:0]                       pos_res,
   output logic [59:0]                       vel_raw,
   output logic [3*COORD_BITS-1:0]           vel_lanes,
   output logic [47:0]                       col_res,
   output logic signed [15:0]                size_res
);

   localparam int CB  = COORD_BITS;
   localparam int VPW = CB + 17;
   localparam int NW  = CB + 22;
   localparam int SQW = 2 * CB + 3;

   typedef struct packed {
      logic [23:0]        age;
      logic [59:0]        pos;
      logic [59:0]        vraw;
      logic [3*CB-1:0]    vl;
      logic [47:0]        col;
      logic signed [15:0] size;
   } res_type;

   // Round a product by the time step: halves go toward plus infinity.
   function automatic logic signed [CB+1:0] rnd_v(input logic signed [VPW-1:0] pr);
      logic [VPW:0] tmp;
      tmp = {pr[VPW-1], pr} + (VPW+1)'(32768);
      return tmp[VPW:16];
   endfunction

   function automatic logic signed [17:0] rnd_c(input logic signed [32:0] pr);
      logic [33:0] tmp;
      tmp = {pr[32], pr} + 34'(32768);
      return tmp[33:16];
   endfunction

   function automatic logic signed [21:0] rnd_s(input logic signed [36:0] pr);
      logic [37:0] tmp;
      tmp = {pr[36], pr} + 38'(32768);
      return tmp[37:16];
   endfunction

   function automatic logic signed [23:0] rnd_a(input logic signed [38:0] pr);
      logic [39:0] tmp;
      tmp = {pr[38], pr} + 40'(32768);
      return tmp[39:16];
   endfunction

   function automatic logic signed [CB-1:0] sat_c(input logic signed [CB+2:0] x);
      logic signed [CB+2:0] hi;
      logic signed [CB+2:0] lo;
      hi = (CB+3)'((1 << (CB - 1)) - 1);
      lo = -hi - (CB+3)'(1);
      if (x > hi) begin
         return hi[CB-1:0];
      end else if (x < lo) begin
         return lo[CB-1:0];
      end
      return x[CB-1:0];
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [17:0] x);
      if (x > 18'sd32767) begin
         return 16'sh7FFF;
      end else if (x < -18'sd32768) begin
         return 16'sh8000;
      end
      return x[15:0];
   endfunction

   // ------------------------------------------------------------------
   // Stage 1: products by the time step and the death test.
   // ------------------------------------------------------------------
   logic                     s1_valid_ff;
   logic                     s1_alive_ff, s1_alive_in;
   logic [15:0]              s1_t_ff;
   logic [23:0]              s1_age_ff;
   logic [59:0]              s1_pos_ff, s1_vel_ff, s1_par_ff;
   logic                     s1_stop_ff, s1_en_ff;
   logic signed [19:0]       s1_str_ff;
   logic [47:0]              s1_col_ff;
   logic signed [15:0]       s1_size_ff;
   logic signed [VPW-1:0]    s1_vprod_ff [3];
   logic signed [VPW-1:0]    s1_vprod_in [3];
   logic signed [32:0]       s1_cprod_ff [3];
   logic signed [32:0]       s1_cprod_in [3];
   logic signed [32:0]       s1_sprod_ff, s1_sprod_in;
   logic signed [36:0]       s1_aprod_ff, s1_aprod_in;

   always_comb begin
      logic [63:0] vx;
      vx = {4'b0000, vel_data};
      for (int k = 0; k < 3; k++) begin
         s1_vprod_in[k] = $signed(vx[k*CB +: CB]) * $signed({1'b0, t_data});
         s1_cprod_in[k] = $signed(crate_data[k*16 +: 16]) * $signed({1'b0, t_data});
      end
      s1_sprod_in = srate_data * $signed({1'b0, t_data});
      s1_aprod_in = attract_str * $signed({1'b0, t_data});
      s1_alive_in = ({1'b0, age_data} + 25'(t_data)) < {1'b0, life_data};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
      s1_alive_ff <= s1_alive_in;
      s1_t_ff     <= t_data;
      s1_age_ff   <= age_data;
      s1_pos_ff   <= pos_data;
      s1_vel_ff   <= vel_data;
      s1_par_ff   <= par_data;
      s1_stop_ff  <= stop_data;
      s1_en_ff    <= attract_en;
      s1_str_ff   <= attract_str;
      s1_col_ff   <= col_data;
      s1_size_ff  <= size_data;
      s1_vprod_ff <= s1_vprod_in;
      s1_cprod_ff <= s1_cprod_in;
      s1_sprod_ff <= s1_sprod_in;
      s1_aprod_ff <= s1_aprod_in;
   end

   // ------------------------------------------------------------------
   // Stage 2: new position, damped velocity, ramps and damped strength.
   // A dead item takes its input fields here.
   // ------------------------------------------------------------------
   pup_pkg::pup_ctrl_type    s2_ctrl_ff;
   res_type                  s2_res_ff, s2_res_in;
   logic signed [CB-1:0]     s2_p_ff [3];
   logic signed [CB-1:0]     s2_p_in [3];
   logic [59:0]              s2_par_ff;
   logic signed [21:0]       s2_sd_ff, s2_sd_in;
   logic [15:0]              s2_t_ff;

   always_comb begin
      logic [63:0]           px;
      logic [63:0]           vx;
      logic [63:0]           ppk;
      logic signed [CB-1:0]  pl;
      logic signed [CB-1:0]  vl;
      logic signed [CB+1:0]  mv;
      logic signed [17:0]    mc;
      logic [47:0]           cpk;
      logic signed [21:0]    ms22;
      px  = {4'b0000, s1_pos_ff};
      vx  = {4'b0000, s1_vel_ff};
      ppk = '0;
      cpk = '0;
      s2_res_in.vl = '0;
      for (int k = 0; k < 3; k++) begin
         pl = $signed(px[k*CB +: CB]);
         vl = $signed(vx[k*CB +: CB]);
         mv = rnd_v(s1_vprod_ff[k]);
         s2_p_in[k] = sat_c((CB+3)'(pl) + (CB+3)'(mv));
         ppk[k*CB +: CB] = s2_p_in[k];
         if (s1_stop_ff) begin
            s2_res_in.vl[k*CB +: CB] = sat_c((CB+3)'(vl) - (CB+3)'(mv));
         end else begin
            s2_res_in.vl[k*CB +: CB] = vl;
         end
         mc = rnd_c(s1_cprod_ff[k]);
         cpk[k*16 +: 16] = sat16(18'($signed(s1_col_ff[k*16 +: 16])) + mc);
      end
      mc = rnd_c(s1_sprod_ff);
      ms22 = rnd_s(s1_aprod_ff);
      s2_res_in.vraw = s1_vel_ff;
      if (s1_alive_ff) begin
         s2_res_in.age  = s1_age_ff + 24'(s1_t_ff);
         s2_res_in.pos  = ppk[59:0];
         s2_res_in.col  = cpk;
         s2_res_in.size = sat16(18'(s1_size_ff) + mc);
      end else begin
         s2_res_in.age  = s1_age_ff;
         s2_res_in.pos  = s1_pos_ff;
         s2_res_in.col  = s1_col_ff;
         s2_res_in.size = s1_size_ff;
      end
      // With stopping, the strength is damped before it is scaled.
      if (s1_stop_ff) begin
         s2_sd_in = 22'(s1_str_ff) - ms22;
      end else begin
         s2_sd_in = 22'(s1_str_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctrl_ff <= '0;
      end else begin
         // The add_en bit holds the enable until stage 5 settles it.
         s2_ctrl_ff <= '{valid: s1_valid_ff, alive: s1_alive_ff, add_en: s1_en_ff};
      end
      s2_res_ff <= s2_res_in;
      s2_p_ff   <= s2_p_in;
      s2_par_ff <= s1_par_ff;
      s2_sd_ff  <= s2_sd_in;
      s2_t_ff   <= s1_t_ff;
   end

   // ------------------------------------------------------------------
   // Stage 3: scaled strength product and direction to the parent.
   // ------------------------------------------------------------------
   pup_pkg::pup_ctrl_type    s3_ctrl_ff;
   res_type                  s3_res_ff;
   logic signed [38:0]       s3_aprod_ff, s3_aprod_in;
   logic signed [CB:0]       s3_d_ff [3];
   logic signed [CB:0]       s3_d_in [3];

   always_comb begin
      logic [63:0] rx;
      rx = {4'b0000, s2_par_ff};
      s3_aprod_in = s2_sd_ff * $signed({1'b0, s2_t_ff});
      for (int k = 0; k < 3; k++) begin
         s3_d_in[k] = (CB+1)'($signed(rx[k*CB +: CB])) - (CB+1)'(s2_p_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ctrl_ff <= '0;
      end else begin
         s3_ctrl_ff <= s2_ctrl_ff;
      end
      s3_res_ff   <= s2_res_ff;
      s3_aprod_ff <= s3_aprod_in;
      s3_d_ff     <= s3_d_in;
   end

   // ------------------------------------------------------------------
   // Stage 4: final strength and squared components.
   // ------------------------------------------------------------------
   pup_pkg::pup_ctrl_type    s4_ctrl_ff;
   res_type                  s4_res_ff;
   logic signed [20:0]       s4_a_ff, s4_a_in;
   logic [2*CB:0]            s4_dsq_ff [3];
   logic [2*CB:0]            s4_dsq_in [3];
   logic signed [CB:0]       s4_d_ff [3];

   always_comb begin
      logic signed [23:0]     ar;
      logic signed [2*CB+1:0] pr;
      ar = rnd_a(s3_aprod_ff);
      s4_a_in = ar[20:0];
      for (int k = 0; k < 3; k++) begin
         pr = s3_d_ff[k] * s3_d_ff[k];
         s4_dsq_in[k] = pr[2*CB:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_ctrl_ff <= '0;
      end else begin
         s4_ctrl_ff <= s3_ctrl_ff;
      end
      s4_res_ff <= s3_res_ff;
      s4_a_ff   <= s4_a_in;
      s4_dsq_ff <= s4_dsq_in;
      s4_d_ff   <= s3_d_ff;
   end

   // ------------------------------------------------------------------
   // Stage 5: squared length and the three numerators d * a.
   // ------------------------------------------------------------------
   pup_pkg::pup_ctrl_type    s5_ctrl_ff, s5_ctrl_in;
   res_type                  s5_res_ff;
   logic [SQW-1:0]           s5_sq_ff, s5_sq_in;
   logic [3*NW-1:0]          s5_num_ff, s5_num_in;

   always_comb begin
      logic signed [NW-1:0] nm;
      s5_sq_in = SQW'(s4_dsq_ff[0]) + SQW'(s4_dsq_ff[1]) + SQW'(s4_dsq_ff[2]);
      for (int k = 0; k < 3; k++) begin
         nm = s4_d_ff[k] * s4_a_ff;
         s5_num_in[k*NW +: NW] = nm;
      end
      s5_ctrl_in.valid  = s4_ctrl_ff.valid;
      s5_ctrl_in.alive  = s4_ctrl_ff.alive;
      s5_ctrl_in.add_en = s4_ctrl_ff.add_en && s4_ctrl_ff.alive && s4_ctrl_ff.valid &&
                          (s5_sq_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_ctrl_ff <= '0;
      end else begin
         s5_ctrl_ff <= s5_ctrl_in;
      end
      s5_res_ff <= s4_res_ff;
      s5_sq_ff  <= s5_sq_in;
      s5_num_ff <= s5_num_in;
   end

   assign ctrl      = s5_ctrl_ff;
   assign sq_sum    = s5_sq_ff;
   assign numer     = s5_num_ff;
   assign age_res   = s5_res_ff.age;
   assign pos_res   = s5_res_ff.pos;
   assign vel_raw   = s5_res_ff.vraw;
   assign vel_lanes = s5_res_ff.vl;
   assign col_res   = s5_res_ff.col;
   assign size_res  = s5_res_ff.size;

endmodule

// ===== rtl/core/pup_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pup_sqrt
// Pipelined integer square root, one root bit per stage, with a side word
// that travels alongside.
// ----------------------------------------------------------------------------
module pup_sqrt #(
   parameter int IN_W   = 60,
   parameter int SIDE_W = 1
) (
   input  logic                clock,
   input  logic [IN_W-1:0]     radicand,
   input  logic [SIDE_W-1:0]   side,
   output logic [IN_W/2-1:0]   root,
   output logic [SIDE_W-1:0]   side_dly
);

   localparam int RW = IN_W / 2;

   logic [RW:0]         rem_ff  [RW];
   logic [RW:0]         rem_in  [RW];
   logic [RW-1:0]       root_ff [RW];
   logic [RW-1:0]       root_in [RW];
   logic [IN_W-1:0]     rad_ff  [RW];
   logic [IN_W-1:0]     rad_in  [RW];
   logic [SIDE_W-1:0]   side_ff [RW];
   logic [SIDE_W-1:0]   side_in [RW];

   // Each stage brings down two radicand bits and tries one root bit.
   always_comb begin
      logic [RW:0]       pr;
      logic [RW-1:0]     pq;
      logic [IN_W-1:0]   px;
      logic [RW+2:0]     rsh;
      logic [RW+2:0]     trial;
      logic [RW+2:0]     diff;
      for (int j = 0; j < RW; j++) begin
         if (j == 0) begin
            pr = '0;
            pq = '0;
            px = radicand;
            side_in[j] = side;
         end else begin
            pr = rem_ff[j-1];
            pq = root_ff[j-1];
            px = rad_ff[j-1];
            side_in[j] = side_ff[j-1];
         end
         rsh   = {pr, px[IN_W-1 -: 2]};
         trial = {1'b0, pq, 2'b01};
         diff  = rsh - trial;
         if (rsh >= trial) begin
            rem_in[j]  = diff[RW:0];
            root_in[j] = {pq[RW-2:0], 1'b1};
         end else begin
            rem_in[j]  = rsh[RW:0];
            root_in[j] = {pq[RW-2:0], 1'b0};
         end
         rad_in[j] = {px[IN_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
      rad_ff  <= rad_in;
      side_ff <= side_in;
   end

   assign root     = root_ff[RW-1];
   assign side_dly = side_ff[RW-1];

endmodule

// ===== rtl/core/pup_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pup_div
// Pipelined rounded division round(numer * 256 / denom), halves away from
// zero, one quotient bit per stage after a setup stage.
// ----------------------------------------------------------------------------
module pup_div #(
   parameter int NUM_W = 42,
   parameter int DEN_W = 30,
   parameter int Q_W   = pup_pkg::QUO_W
) (
   input  logic                     clock,
   input  logic signed [NUM_W-1:0]  numer,
   input  logic [DEN_W-1:0]         denom,
   output logic signed [Q_W:0]      quot
);

   localparam int N_W = NUM_W + 10;
   localparam int D_W = DEN_W + 1;
   localparam int C_W = (N_W > D_W + Q_W) ? N_W : D_W + Q_W;

   // Setup stage: dividend 512|n| + len and divisor 2 len.
   logic [N_W-1:0]   p_n_ff, p_n_in;
   logic [D_W-1:0]   p_d_ff;
   logic             p_neg_ff;

   always_comb begin
      logic [NUM_W-1:0] mag;
      if (numer[NUM_W-1]) begin
         mag = NUM_W'(-numer);
      end else begin
         mag = NUM_W'(numer);
      end
      p_n_in = (N_W'(mag) << 9) + N_W'(denom);
   end

   always_ff @(posedge clock) begin
      p_n_ff   <= p_n_in;
      p_d_ff   <= {denom, 1'b0};
      p_neg_ff <= numer[NUM_W-1];
   end

   // Restoring steps, most significant quotient bit first.
   logic [N_W-1:0]   rem_ff [Q_W];
   logic [N_W-1:0]   rem_in [Q_W];
   logic [Q_W-1:0]   q_ff   [Q_W];
   logic [Q_W-1:0]   q_in   [Q_W];
   logic [D_W-1:0]   d_ff   [Q_W];
   logic [D_W-1:0]   d_in   [Q_W];
   logic             neg_ff [Q_W];
   logic             neg_in [Q_W];

   always_comb begin
      logic [N_W-1:0] pr;
      logic [Q_W-1:0] pq;
      logic [D_W-1:0] pd;
      logic           pn;
      logic [C_W-1:0] dsh;
      logic [C_W-1:0] rw;
      for (int i = 0; i < Q_W; i++) begin
         if (i == 0) begin
            pr = p_n_ff;
            pq = '0;
            pd = p_d_ff;
            pn = p_neg_ff;
         end else begin
            pr = rem_ff[i-1];
            pq = q_ff[i-1];
            pd = d_ff[i-1];
            pn = neg_ff[i-1];
         end
         dsh = C_W'(pd) << (Q_W - 1 - i);
         rw  = C_W'(pr);
         if (rw >= dsh) begin
            rem_in[i] = N_W'(rw - dsh);
            q_in[i]   = {pq[Q_W-2:0], 1'b1};
         end else begin
            rem_in[i] = pr;
            q_in[i]   = {pq[Q_W-2:0], 1'b0};
         end
         d_in[i]   = pd;
         neg_in[i] = pn;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
      d_ff   <= d_in;
      neg_ff <= neg_in;
   end

   assign quot = neg_ff[Q_W-1] ? -$signed({1'b0, q_ff[Q_W-1]})
                               : $signed({1'b0, q_ff[Q_W-1]});

endmodule

// ===== rtl/core/particle_update_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_update_step
// Advances one particle by one time step: age, position, damping,
// attraction toward a parent point, and color and size ramps.
// ----------------------------------------------------------------------------
// A particle item is taken at every clock edge where start is high and busy
// is low, one item per cycle with no gaps. busy is high during reset and in
// the cycle after it. Each item's result appears on the rsp_ ports, marked by
// rsp_valid, for exactly one cycle, in input order, after the front stages,
// the root pipeline, the divide pipeline and the result register; the
// receiver must take it then. The root pipeline yields one length bit per
// stage, and the divide pipeline yields one quotient bit per stage. The user
// must write registers through csr_we, csr_index and csr_wdata only while no
// item is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "particle_update_step_macros.svh"

module particle_update_step #(
   parameter int COORD_BITS = pup_pkg::COORD_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [15:0]                           req_time_delta,
   input  logic [23:0]                           req_age,
   input  logic [23:0]                           req_lifetime,
   input  logic [59:0]                           req_position,
   input  logic [59:0]                           req_velocity,
   input  logic [59:0]                           req_parent_position,
   input  logic                                  req_stopping,
   input  logic [47:0]                           req_color,
   input  logic [47:0]                           req_color_rate,
   input  logic signed [15:0]                    req_size,
   input  logic signed [15:0]                    req_size_rate,
   input  logic                                  csr_we,
   input  logic [pup_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [19:0]                           csr_wdata,
   output logic                                  rsp_valid,
   output logic                                  rsp_alive,
   output logic [23:0]                           rsp_new_age,
   output logic [59:0]                           rsp_new_position,
   output logic [59:0]                           rsp_new_velocity,
   output logic [47:0]                           rsp_new_color,
   output logic signed [15:0]                    rsp_new_size
);

   localparam int CB    = COORD_BITS;
   localparam int RW    = CB + 10;
   localparam int SW    = 2 * RW;
   localparam int NW    = CB + 22;
   localparam int QW    = pup_pkg::QUO_W;
   localparam int DL    = RW + QW + 1;
   localparam int PAY_W = 24 + 60 + 60 + 3 * CB + 48 + 16;
   localparam int SUM_W = CB + QW + 2;

   function automatic logic signed [CB-1:0] sat_v(input logic signed [SUM_W-1:0] x);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'((1 << (CB - 1)) - 1);
      lo = -hi - SUM_W'(1);
      if (x > hi) begin
         return hi[CB-1:0];
      end else if (x < lo) begin
         return lo[CB-1:0];
      end
      return x[CB-1:0];
   endfunction

   // Configuration registers and the post-reset busy flag.
   logic               busy_ff;
   logic               en_ff;
   logic signed [19:0] str_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         en_ff   <= 1'b0;
         str_ff  <= '0;
      end else begin
         busy_ff <= 1'b0;
         if (csr_we) begin
            case (csr_index)
               pup_pkg::REG_ATTRACT_ENABLE: begin
                  en_ff <= csr_wdata[0];
               end
               pup_pkg::REG_ATTRACT_STRENGTH: begin
                  str_ff <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign busy = busy_ff;

   // Front stages.
   pup_pkg::pup_ctrl_type   f_ctrl;
   logic [2*CB+2:0]         f_sq;
   logic [3*NW-1:0]         f_num;
   logic [23:0]             f_age;
   logic [59:0]             f_pos;
   logic [59:0]             f_vraw;
   logic [3*CB-1:0]         f_vl;
   logic [47:0]             f_col;
   logic signed [15:0]      f_size;

   pup_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (start && !busy_ff),
      .t_data     (req_time_delta),
      .age_data   (req_age),
      .life_data  (req_lifetime),
      .pos_data   (req_position),
      .vel_data   (req_velocity),
      .par_data   (req_parent_position),
      .stop_data  (req_stopping),
      .col_data   (req_color),
      .crate_data (req_color_rate),
      .size_data  (req_size),
      .srate_data (req_size_rate),
      .attract_en (en_ff),
      .attract_str(str_ff),
      .ctrl       (f_ctrl),
      .sq_sum     (f_sq),
      .numer      (f_num),
      .age_res    (f_age),
      .pos_res    (f_pos),
      .vel_raw    (f_vraw),
      .vel_lanes  (f_vl),
      .col_res    (f_col),
      .size_res   (f_size)
   );

   // Length of the direction, scaled by 256, with the numerators alongside.
   logic [RW-1:0]     sq_root;
   logic [3*NW-1:0]   sq_num;

   pup_sqrt #(
      .IN_W   (SW),
      .SIDE_W (3 * NW)
   ) u_sqrt (
      .clock    (clock),
      .radicand ({1'b0, f_sq, 16'h0000}),
      .side     (f_num),
      .root     (sq_root),
      .side_dly (sq_num)
   );

   // One divide pipeline per lane.
   logic signed [QW:0] q_lane [3];

   for (genvar k = 0; k < 3; k++) begin : g_div
      pup_div #(
         .NUM_W (NW),
         .DEN_W (RW),
         .Q_W   (QW)
      ) u_div (
         .clock (clock),
         .numer (sq_num[k*NW +: NW]),
         .denom (sq_root),
         .quot  (q_lane[k])
      );
   end

   // Delay line for the fields that wait on the root and divide.
   pup_pkg::pup_ctrl_type   ctrl_ff [DL];
   logic [PAY_W-1:0]        pay_ff  [DL];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DL; i++) begin
            ctrl_ff[i] <= '0;
         end
      end else begin
         ctrl_ff[0] <= f_ctrl;
         for (int i = 1; i < DL; i++) begin
            ctrl_ff[i] <= ctrl_ff[i-1];
         end
      end
      pay_ff[0] <= {f_age, f_pos, f_vraw, f_vl, f_col, f_size};
      for (int i = 1; i < DL; i++) begin
         pay_ff[i] <= pay_ff[i-1];
      end
   end

   // Final stage: add the attraction to each velocity lane when add_en is set; a dead item takes its raw velocity.
   logic [23:0]          d_age;
   logic [59:0]          d_pos;
   logic [59:0]          d_vraw;
   logic [3*CB-1:0]      d_vl;
   logic [47:0]          d_col;
   logic signed [15:0]   d_size;
   logic [59:0]          vel_out_in;

   assign {d_age, d_pos, d_vraw, d_vl, d_col, d_size} = pay_ff[DL-1];

   always_comb begin
      logic [63:0]          vpk;
      logic signed [CB-1:0] vl;
      vpk = '0;
      for (int k = 0; k < 3; k++) begin
         vl = $signed(d_vl[k*CB +: CB]);
         if (ctrl_ff[DL-1].add_en) begin
            vpk[k*CB +: CB] = sat_v(SUM_W'(vl) + SUM_W'(q_lane[k]));
         end else begin
            vpk[k*CB +: CB] = vl;
         end
      end
      if (ctrl_ff[DL-1].alive) begin
         vel_out_in = vpk[59:0];
      end else begin
         vel_out_in = d_vraw;
      end
   end

   // Result register.
   logic                 rsp_valid_ff;
   logic                 rsp_alive_ff;
   logic [23:0]          rsp_age_ff;
   logic [59:0]          rsp_pos_ff;
   logic [59:0]          rsp_vel_ff;
   logic [47:0]          rsp_col_ff;
   logic signed [15:0]   rsp_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctrl_ff[DL-1].valid;
      end
      rsp_alive_ff <= ctrl_ff[DL-1].alive;
      rsp_age_ff   <= d_age;
      rsp_pos_ff   <= d_pos;
      rsp_vel_ff   <= vel_out_in;
      rsp_col_ff   <= d_col;
      rsp_size_ff  <= d_size;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_alive        = rsp_alive_ff;
   assign rsp_new_age      = rsp_age_ff;
   assign rsp_new_position = rsp_pos_ff;
   assign rsp_new_velocity = rsp_vel_ff;
   assign rsp_new_color    = rsp_col_ff;
   assign rsp_new_size     = rsp_size_ff;

   // Checks on the attraction path and on the reporting of dead items.
   `PUP_ASSERT_IMPL(a_pull_only_live, ctrl_ff[DL-1].add_en, ctrl_ff[DL-1].alive && ctrl_ff[DL-1].valid, "attraction applied to an item that is not a live particle")
   `PUP_ASSERT_IMPL(a_root_nonzero, ctrl_ff[RW-1].add_en, sq_root != '0, "zero direction length reached the divider for a pulled item")
   `PUP_ASSERT_NEXT(a_dead_reported, ctrl_ff[DL-1].valid && !ctrl_ff[DL-1].alive, rsp_valid && !rsp_alive, "dead item not reported as dead")

endmodule

// ===== tb/tb_particle_update_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_particle_update_step
// Self-checking bench for the particle update step. Directed and random
// particles are streamed in under several sender idle patterns and across
// attraction settings; each result is compared with an in-bench fixed-point
// model of the update.
// ----------------------------------------------------------------------------
module tb_particle_update_step;

   localparam int CB = pup_pkg::COORD_BITS_DEF;
   localparam int LATENCY = 5 + (CB + 10) + 22 + 1;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct {
      logic        alive;
      logic [23:0] age;
      logic [59:0] pos;
      logic [59:0] vel;
      logic [47:0] col;
      logic [15:0] size;
   } particle_result_type;

   logic clock, reset, start, busy;
   logic [15:0] req_time_delta;
   logic [23:0] req_age, req_lifetime;
   logic [59:0] req_position, req_velocity, req_parent_position;
   logic req_stopping;
   logic [47:0] req_color, req_color_rate;
   logic signed [15:0] req_size, req_size_rate;
   logic csr_we;
   logic [pup_pkg::CSR_IDX_W-1:0] csr_index;
   logic [19:0] csr_wdata;
   logic rsp_valid, rsp_alive;
   logic [23:0] rsp_new_age;
   logic [59:0] rsp_new_position, rsp_new_velocity;
   logic [47:0] rsp_new_color;
   logic signed [15:0] rsp_new_size;

   // Predictor copy of the configuration.
   logic        attract_on;
   logic [19:0] attract_str;

   particle_result_type expected_results[$];
   int mismatch_count = 0;
   int unexpected_count = 0;
   int result_count = 0;
   int item_count = 0;
   int idle_cycles = 0;
   int idle_percent = 0;

   particle_update_step DUT (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Fixed-point helpers.
   function automatic longint sat_to(longint v, int w);
      longint hi, lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
   endfunction

   function automatic longint scale_by_dt(longint x, longint t);
      return (x * t + 32768) >>> 16;
   endfunction

   function automatic longint coord_lane(logic [59:0] p, int k);
      logic [CB-1:0] f;
      f = p[k*CB +: CB];
      return longint'(signed'(f));
   endfunction

   function automatic longint color_lane(logic [47:0] c, int k);
      logic [15:0] f;
      f = c[k*16 +: 16];
      return longint'(signed'(f));
   endfunction

   function automatic longint root_floor(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return longint'(r);
   endfunction

   function automatic longint rounded_quotient(longint n, longint d);
      longint m, q;
      m = n < 0 ? -n : n;
      q = (2 * m + d) / (2 * d);
      return n < 0 ? -q : q;
   endfunction

   // Computes the advanced particle for one item.
   function automatic particle_result_type advance_particle(
         logic [15:0] t16, logic [23:0] age, logic [23:0] life,
         logic [59:0] pos, logic [59:0] vel, logic [59:0] par, logic stop,
         logic [47:0] col, logic [47:0] crate, logic [15:0] sz,
         logic [15:0] srate);
      particle_result_type r;
      longint t, s, a, sq, len, c;
      longint p[3], v[3], d[3];
      t = longint'(t16);
      r.pos = '0;
      r.vel = '0;
      r.col = '0;
      if (longint'(age) + t >= longint'(life)) begin
         r.alive = 0;
         r.age = age;
         r.pos = pos;
         r.vel = vel;
         r.col = col;
         r.size = sz;
         return r;
      end
      r.alive = 1;
      r.age = 24'(longint'(age) + t);
      for (int k = 0; k < 3; k++) begin
         v[k] = coord_lane(vel, k);
         p[k] = sat_to(coord_lane(pos, k) + scale_by_dt(v[k], t), CB);
         if (stop) v[k] = sat_to(v[k] - scale_by_dt(v[k], t), CB);
      end
      if (attract_on) begin
         s = longint'(signed'(attract_str));
         if (stop) s = s - scale_by_dt(s, t);
         a = scale_by_dt(s, t);
         sq = 0;
         for (int k = 0; k < 3; k++) begin
            d[k] = coord_lane(par, k) - p[k];
            sq += d[k] * d[k];
         end
         if (sq != 0) begin
            len = root_floor(longint'(sq) << 16);
            for (int k = 0; k < 3; k++)
               v[k] = sat_to(v[k] + rounded_quotient(d[k] * a * 256, len), CB);
         end
      end
      for (int k = 0; k < 3; k++) begin
         c = color_lane(col, k) + scale_by_dt(color_lane(crate, k), t);
         r.col[k*16 +: 16] = 16'(sat_to(c, 16));
         r.pos[k*CB +: CB] = CB'(p[k]);
         r.vel[k*CB +: CB] = CB'(v[k]);
      end
      r.size = 16'(sat_to(longint'(signed'(sz)) +
                          scale_by_dt(longint'(signed'(srate)), t), 16));
      return r;
   endfunction

   // Result checker; results cannot be stalled, so every strobe is taken.
   always @(posedge clock) begin
      particle_result_type e;
      if (!reset && rsp_valid) begin
         result_count++;
         if (expected_results.size() == 0) begin
            unexpected_count++;
            mismatch_count++;
            if (mismatch_count <= 10) $display("Unexpected result item.");
         end else begin
            e = expected_results.pop_front();
            if (rsp_alive !== e.alive || rsp_new_age !== e.age ||
                rsp_new_position !== e.pos || rsp_new_velocity !== e.vel ||
                rsp_new_color !== e.col || rsp_new_size !== e.size) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Mismatch: exp alive %0d age %h pos %h vel %h col %h size %h",
                           e.alive, e.age, e.pos, e.vel, e.col, e.size);
                  $display("          got alive %0d age %h pos %h vel %h col %h size %h",
                           rsp_alive, rsp_new_age, rsp_new_position,
                           rsp_new_velocity, rsp_new_color, rsp_new_size);
               end
            end
         end
      end
   end

   // Watchdog on cycles with no accepted item or result.
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d items pending.", expected_results.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Sends one particle, with a random idle gap in front of it.
   task automatic send_particle(logic [15:0] t, logic [23:0] age, logic [23:0] life,
                                logic [59:0] pos, logic [59:0] vel,
                                logic [59:0] par, logic stop,
                                logic [47:0] col, logic [47:0] crate,
                                logic [15:0] sz, logic [15:0] srate);
      while ($urandom_range(99) < idle_percent) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1;
      req_time_delta <= t;
      req_age <= age;
      req_lifetime <= life;
      req_position <= pos;
      req_velocity <= vel;
      req_parent_position <= par;
      req_stopping <= stop;
      req_color <= col;
      req_color_rate <= crate;
      req_size <= sz;
      req_size_rate <= srate;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_results.push_back(advance_particle(t, age, life, pos, vel, par,
                                                  stop, col, crate, sz, srate));
      item_count++;
   endtask

   // Lowers start and waits for the pipeline to drain.
   task automatic drain_pipeline();
      int n;
      start <= 0;
      n = 0;
      while (expected_results.size() != 0 && n < 20 * LATENCY) begin
         @(posedge clock);
         n++;
      end
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_register(logic [pup_pkg::CSR_IDX_W-1:0] idx, logic [19:0] value);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 0;
      if (idx == pup_pkg::REG_ATTRACT_ENABLE) attract_on = value[0];
      else attract_str = value;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Mostly small-magnitude coordinates so motion does not always saturate.
   function automatic logic [59:0] rand_coords();
      logic [59:0] v;
      v = 60'(rand64());
      if ($urandom_range(3) != 0)
         for (int k = 0; k < 3; k++)
            v[k*CB +: CB] = CB'(int'($urandom_range(8191)) - 4096);
      return v;
   endfunction

   task automatic send_random_particle();
      logic [23:0] age, life;
      logic [15:0] t;
      t = 16'($urandom);
      age = $urandom_range(3) == 0 ? 24'($urandom) : 24'($urandom_range(1 << 20));
      // Most particles live, some die, a few sit on the boundary.
      case ($urandom_range(9))
         0: life = age + t;
         1: life = 24'($urandom);
         2: life = age;
         default: life = (age > 24'hFE0000) ? 24'hFFFFFF :
                         24'(age + t + 1 + $urandom_range(65535));
      endcase
      send_particle(t, age, life, rand_coords(), rand_coords(), rand_coords(),
                    1'($urandom_range(1)), 48'(rand64()), 48'(rand64()),
                    16'($urandom), 16'($urandom));
   endtask

   task automatic test_directed();
      logic [59:0] max_c, min_c;
      for (int k = 0; k < 3; k++) begin
         max_c[k*CB +: CB] = {1'b0, {(CB-1){1'b1}}};
         min_c[k*CB +: CB] = {1'b1, {(CB-1){1'b0}}};
      end
      // Dead particles, including age plus step exactly at the lifetime.
      send_particle(16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, '1, '1, '1, 1'b1, '1, '1, '1, '1);
      send_particle(16'd100, 24'd900, 24'd1000, max_c, min_c, '0, 1'b0, '1, '0,
                    16'h8000, 16'h0000);
      send_particle(16'd0, 24'd0, 24'd0, '0, '0, '0, 1'b0, '0, '0, 16'h0000, 16'h0000);
      // Live extremes with saturation in every direction.
      send_particle(16'hFFFF, 24'd0, 24'hFFFFFF, max_c, max_c, min_c, 1'b1,
                    48'h7FFF7FFF7FFF, 48'h7FFF7FFF7FFF, 16'h7FFF, 16'h7FFF);
      send_particle(16'hFFFF, 24'd0, 24'hFFFFFF, min_c, min_c, max_c, 1'b0,
                    48'h800080008000, 48'h800080008000, 16'h8000, 16'h8000);
      // Zero-length direction: parent sits where the particle lands.
      send_particle(16'd0, 24'd5, 24'd10, 60'h0000100002000003, '0,
                    60'h0000100002000003, 1'b0, '0, '0, 16'h0000, 16'h0000);
      send_particle(16'h8000, 24'd0, 24'hFFFFFF, '0, 60'h0000100002000003, '0, 1'b1,
                    48'h000100020003, 48'h123456789ABC, 16'h0100, 16'hFF00);
      send_particle(16'd1, 24'hFFFFFD, 24'hFFFFFF, max_c, '0, min_c, 1'b0, '0, '0,
                    16'h0000, 16'h0000);
      repeat (8) send_random_particle();
   endtask

   task automatic test_random_phase(int percent, int count);
      idle_percent = percent;
      for (int i = 0; i < count; i++) begin
         // Some unpaced bursts inside every phase.
         if (i % 50 == 25) idle_percent = 0;
         if (i % 50 == 40) idle_percent = percent;
         send_random_particle();
      end
      idle_percent = 0;
   endtask

   task automatic test_attraction_settings();
      write_register(pup_pkg::REG_ATTRACT_ENABLE, 20'd1);
      write_register(pup_pkg::REG_ATTRACT_STRENGTH, 20'h7FFFF);
      test_random_phase(0, 150);
      drain_pipeline();
      write_register(pup_pkg::REG_ATTRACT_STRENGTH, 20'h80000);
      test_random_phase(77, 150);
      drain_pipeline();
      write_register(pup_pkg::REG_ATTRACT_STRENGTH, 20'($urandom_range(4095)));
      test_random_phase(26, 250);
      drain_pipeline();
      write_register(pup_pkg::REG_ATTRACT_STRENGTH, 20'($urandom));
      test_random_phase(77, 200);
      drain_pipeline();
      write_register(pup_pkg::REG_ATTRACT_STRENGTH, 20'h00000);
      test_random_phase(0, 100);
      drain_pipeline();
      write_register(pup_pkg::REG_ATTRACT_STRENGTH, 20'hFFF00);
      test_random_phase(26, 200);
      drain_pipeline();
      write_register(pup_pkg::REG_ATTRACT_ENABLE, 20'd0);
   endtask

   initial begin
      reset = 1;
      start = 0;
      csr_we = 0;
      csr_index = '0;
      csr_wdata = '0;
      req_time_delta = '0;
      req_age = '0;
      req_lifetime = '0;
      req_position = '0;
      req_velocity = '0;
      req_parent_position = '0;
      req_stopping = 0;
      req_color = '0;
      req_color_rate = '0;
      req_size = '0;
      req_size_rate = '0;
      attract_on = 0;
      attract_str = '0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      test_directed();
      drain_pipeline();
      write_register(pup_pkg::REG_ATTRACT_ENABLE, 20'd1);
      write_register(pup_pkg::REG_ATTRACT_STRENGTH, 20'h00400);
      test_directed();
      drain_pipeline();
      write_register(pup_pkg::REG_ATTRACT_ENABLE, 20'd0);
      test_random_phase(0, 200);
      drain_pipeline();
      test_attraction_settings();
      test_random_phase(77, 100);
      drain_pipeline();

      $display("Covered %0d particle items and %0d results over idle, busy and",
               item_count, result_count);
      $display("attraction settings from most negative to most positive strength.");
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d unexpected, %0d still pending.",
                  mismatch_count, unexpected_count, expected_results.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== particle_update_step.f =====
+incdir+rtl/core
rtl/core/pup_pkg.sv
rtl/core/pup_front.sv
rtl/core/pup_sqrt.sv
rtl/core/pup_div.sv
rtl/core/particle_update_step.sv
tb/tb_particle_update_step.sv
